// ===== hw/rtl/lfp_pkg.sv =====
// Shared constants for the length-prefixed frame parser.
// Used by the parser top level and by its port checker.
`default_nettype none

package lfp_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int TYPE_AT      = 4;
  localparam int ID_AT        = 6;
  localparam int HC_W         = $clog2(HEADER_BYTES);

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4096;

  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/length_prefixed_frame_parser_unit.sv =====
// Length-prefixed frame parser top level.
// Depends on lfp_pkg for header layout and status codes.
//
// Usage: raw stream bytes enter on data_byte with in_valid/in_stall; one word is
// taken at each rising edge with in_valid high and in_stall low. Every stream
// starts with a 10-byte big-endian header (length, type, id). Header bytes
// give no result except the tenth, which gives an error result when the
// length is above max_payload, an empty-frame result when it is zero, and
// otherwise opens the payload. Each payload byte then gives one result word
// carrying the header fields; the final one has last set.
// Results leave on out_valid/out_stall through a single output register.
// A result is registered and reaches the outputs in the cycle after its byte is taken.
// Throughput: one byte per cycle unless stalled; the parse step is a 32-bit
// compare and a 32-bit decrement between the input and the output register.
// When the receiver stalls a valid result, in_stall rises in the same cycle
// and the held result stays unchanged until taken. Synchronous reset empties the
// output register, returns to header hunting and sets max_payload to 4096. The
// user must write max_payload by cfg_we only while idle; it is not enforced.
`default_nettype none

module length_prefixed_frame_parser_unit
  import lfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      msg_type,
  output logic [31:0]      msg_id,
  output logic [31:0]      payload_length,
  output logic [7:0]       data_byte_out,
  output logic             last
);

  logic [31:0]     max_payload;
  logic [HC_W-1:0] header_count, header_count_next;
  logic [31:0]     length_word, length_word_next;
  logic [15:0]     type_word, type_word_next;
  logic [31:0]     id_word, id_word_next;
  logic [31:0]     bytes_left, bytes_left_next;
  logic            in_payload, in_payload_next;

  logic            accept;
  logic            res_valid;
  logic [1:0]      res_status;
  logic [7:0]      res_byte;
  logic            res_last;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    header_count_next = header_count;
    length_word_next  = length_word;
    type_word_next    = type_word;
    id_word_next      = id_word;
    bytes_left_next   = bytes_left;
    in_payload_next   = in_payload;
    res_valid         = 1'b0;
    res_status        = ST_PAYLOAD;
    res_byte          = '0;
    res_last          = 1'b0;
    if (in_payload) begin
      res_valid = 1'b1;
      res_byte  = data_byte;
      if (bytes_left <= 32'd1) begin
        bytes_left_next   = '0;
        res_last          = 1'b1;
        in_payload_next   = 1'b0;
        header_count_next = '0;
      end else begin
        bytes_left_next = bytes_left - 32'd1;
      end
    end else begin
      if (header_count < HC_W'(TYPE_AT)) begin
        length_word_next = {length_word[23:0], data_byte};
      end else if (header_count < HC_W'(ID_AT)) begin
        type_word_next = {type_word[7:0], data_byte};
      end else begin
        id_word_next = {id_word[23:0], data_byte};
      end
      if (header_count >= HC_W'(HEADER_BYTES - 1)) begin
        header_count_next = '0;
        if (length_word_next > max_payload) begin
          res_valid  = 1'b1;
          res_status = ST_ERROR;
          res_last   = 1'b1;
        end else if (length_word_next == 32'd0) begin
          res_valid  = 1'b1;
          res_status = ST_EMPTY;
          res_last   = 1'b1;
        end else begin
          bytes_left_next = length_word_next;
          in_payload_next = 1'b1;
        end
      end else begin
        header_count_next = header_count + HC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload  <= MAX_PAYLOAD_RESET;
      header_count <= '0;
      length_word  <= '0;
      type_word    <= '0;
      id_word      <= '0;
      bytes_left   <= '0;
      in_payload   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
      if (accept) begin
        header_count <= header_count_next;
        length_word  <= length_word_next;
        type_word    <= type_word_next;
        id_word      <= id_word_next;
        bytes_left   <= bytes_left_next;
        in_payload   <= in_payload_next;
        out_valid    <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      status         <= res_status;
      msg_type       <= type_word_next;
      msg_id         <= id_word_next;
      payload_length <= length_word_next;
      data_byte_out  <= res_byte;
      last           <= res_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfp_checker.sv =====
// Port-level checker for the length-prefixed frame parser.
// Depends on lfp_pkg; bound to length_prefixed_frame_parser_unit below.
`default_nettype none

module lfp_checker
  import lfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [15:0] msg_type,
  input wire logic [31:0] msg_id,
  input wire logic [31:0] payload_length,
  input wire logic [7:0]  data_byte_out,
  input wire logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(msg_type)
      && $stable(msg_id) && $stable(payload_length) && $stable(data_byte_out)
      && $stable(last))
    else $error("stalled result word changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_non_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY || status == ST_ERROR) |-> last && data_byte_out == 8'd0)
    else $error("header-only result without last or with data");

  a_length_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_EMPTY) == (payload_length == 32'd0))
    else $error("empty status does not match zero length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind length_prefixed_frame_parser_unit lfp_checker u_lfp_checker (.*);

`default_nettype wire

// ===== tb/sv/length_prefixed_frame_parser_unit_tb.sv =====
// Self-checking bench for length_prefixed_frame_parser_unit: a scripted byte table,
// then random framed streams under several max_payload settings and idle mixes.
// Depends on lfp_pkg and parser RTL; every result word is checked vs. table or parse model.
module length_prefixed_frame_parser_unit_tb
  import lfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] msg_type;
    logic [31:0] msg_id;
    logic [31:0] payload_length;
    logic [7:0]  data_byte_out;
    logic        last;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  byte_in;
    logic        has_want;
    frame_word_t want;
  } script_row_t;

  localparam frame_word_t NO_WORD = '0;
  localparam int SCRIPT_LEN = 31;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 85;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, '{ST_ERROR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b1}},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b1, '{ST_EMPTY, 16'h0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h01, 1'b0, NO_WORD},
    '{8'h12, 1'b0, NO_WORD},
    '{8'h34, 1'b0, NO_WORD},
    '{8'h89, 1'b0, NO_WORD},
    '{8'hAB, 1'b0, NO_WORD},
    '{8'hCD, 1'b0, NO_WORD},
    '{8'hEF, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, '{ST_PAYLOAD, 16'h1234, 32'h89AB_CDEF, 32'd1, 8'hFF, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] msg_type;
  logic [31:0] msg_id;
  logic [31:0] payload_length;
  logic [7:0]  data_byte_out;
  logic        last;

  // parse model state
  logic [31:0]     cur_max;
  logic [HC_W-1:0] hdr_count;
  logic [31:0]     len_w;
  logic [15:0]     type_w;
  logic [31:0]     id_w;
  logic [31:0]     remaining;
  logic            in_body;

  frame_word_t pending_words [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          byte_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;

  length_prefixed_frame_parser_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .msg_type       (msg_type),
    .msg_id         (msg_id),
    .payload_length (payload_length),
    .data_byte_out  (data_byte_out),
    .last           (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit parse_byte(input logic [7:0] b, output frame_word_t w);
    logic fin;
    w = NO_WORD;
    if (in_body) begin
      if (remaining <= 32'd1) begin
        remaining = '0;
        fin = 1'b1;
        in_body = 1'b0;
        hdr_count = '0;
      end else begin
        remaining = remaining - 32'd1;
        fin = 1'b0;
      end
      w = '{ST_PAYLOAD, type_w, id_w, len_w, b, fin};
      return 1'b1;
    end
    if (hdr_count < TYPE_AT) len_w = {len_w[23:0], b};
    else if (hdr_count < ID_AT) type_w = {type_w[7:0], b};
    else id_w = {id_w[23:0], b};
    if (hdr_count + 1 < HEADER_BYTES) begin
      hdr_count = hdr_count + 1'b1;
      return 1'b0;
    end
    hdr_count = '0;
    if (len_w > cur_max) begin
      w = '{ST_ERROR, type_w, id_w, len_w, 8'h00, 1'b1};
      return 1'b1;
    end
    if (len_w == '0) begin
      w = '{ST_EMPTY, type_w, id_w, len_w, 8'h00, 1'b1};
      return 1'b1;
    end
    remaining = len_w;
    in_body = 1'b1;
    return 1'b0;
  endfunction

  // enter and leave at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic has_want = 1'b0,
                           input frame_word_t want = NO_WORD);
    frame_word_t w;
    bit got;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = parse_byte(b, w);
    if (has_want) pending_words.push_back(want);
    else if (got) pending_words.push_back(w);
    byte_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_max(input logic [31:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_max = v;
  endtask

  task automatic send_frame(input int frame_no);
    logic [31:0] len;
    logic [15:0] kind;
    logic [31:0] ident;
    logic [79:0] hdr;
    kind = 16'($urandom);
    ident = $urandom;
    case ($urandom_range(9))
      0: len = '0;
      1, 2, 3, 4: len = $urandom_range(1, 8);
      5: len = $urandom_range(9, 40);
      6: len = (cur_max <= 32'd40) ? cur_max : 32'($urandom_range(1, 8));
      7: len = (cur_max != 32'hFFFF_FFFF) ? cur_max + 32'd1 : 32'd40;
      default: begin
        len = $urandom;
        if (len <= cur_max) len = len % 41;
      end
    endcase
    hdr = {len, kind, ident};
    for (int i = 0; i < HEADER_BYTES; i++) send_byte(hdr[79 - 8*i -: 8]);
    if (len <= cur_max)
      for (int i = 0; i < int'(len); i++) send_byte(8'($urandom));
    if (frame_no % 7 == 3) drain_results();
  endtask

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin : result_check
    frame_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        if (status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status);
          mismatches++;
        end
        if (msg_type !== w.msg_type) begin
          $error("msg_type: expected %h, got %h", w.msg_type, msg_type);
          mismatches++;
        end
        if (msg_id !== w.msg_id) begin
          $error("msg_id: expected %h, got %h", w.msg_id, msg_id);
          mismatches++;
        end
        if (payload_length !== w.payload_length) begin
          $error("payload_length: expected %h, got %h", w.payload_length, payload_length);
          mismatches++;
        end
        if (data_byte_out !== w.data_byte_out) begin
          $error("data_byte_out: expected %h, got %h", w.data_byte_out, data_byte_out);
          mismatches++;
        end
        if (last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("length_prefixed_frame_parser_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase_start;
    int frames;
    logic [31:0] new_max;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    out_stall = 1'b0;
    cur_max = MAX_PAYLOAD_RESET;
    hdr_count = '0;
    len_w = '0;
    type_w = '0;
    id_w = '0;
    remaining = '0;
    in_body = 1'b0;
    frames = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_byte(SCRIPT[i].byte_in, SCRIPT[i].has_want, SCRIPT[i].want);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: new_max = '0;
        1: new_max = 32'hFFFF_FFFF;
        2: new_max = 32'd16;
        3: new_max = 32'd1;
        4: new_max = $urandom;
        5: new_max = $urandom_range(2, 40);
        6: new_max = 32'hFFFF_FFFE;
        default: new_max = MAX_PAYLOAD_RESET;
      endcase
      write_max(new_max);
      case (p % 4)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 73;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 73;
        end
        default: begin
          in_idle_pct = 23;
          out_stall_pct = 23;
        end
      endcase
      phase_start = byte_count;
      while (byte_count - phase_start < PHASE_BYTES) begin
        send_frame(frames);
        frames++;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("length_prefixed_frame_parser_unit_tb passed");
    end else begin
      $display("length_prefixed_frame_parser_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lfp_pkg.sv
hw/rtl/length_prefixed_frame_parser_unit.sv
hw/rtl/lfp_checker.sv
tb/sv/length_prefixed_frame_parser_unit_tb.sv
